>>> rtl/mdsf_pkg.sv
package mdsf_pkg;

  // Stream scanner sizing
  localparam int unsigned MarkerLen   = 10;
  localparam int unsigned PosW        = 25;
  localparam int unsigned OffsetW     = 24;
  localparam int unsigned SizeW       = 25;
  localparam int unsigned VerW        = 64;
  localparam int unsigned VerLenW     = 4;
  localparam logic [VerLenW-1:0] MaxVerBytes = 4'd8;

  // APB register map, 8-byte stride
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 64;
  typedef enum logic {
    REG_TARGET_VERSION = 1'b0,
    REG_TARGET_VER_LEN = 1'b1
  } reg_idx_e;

  // Marker "0x20140731", element 0 is the oldest byte of the window
  localparam logic [MarkerLen-1:0][7:0] Marker = {
    8'h31, 8'h33, 8'h37, 8'h30, 8'h34, 8'h31, 8'h30, 8'h32, 8'h78, 8'h30
  };

  // Configuration handed to the scanner
  typedef struct packed {
    logic [VerW-1:0]    target_version;
    logic [VerLenW-1:0] target_version_length;
  } cfg_t;

  // Result word produced by the scanner for one input byte
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [OffsetW-1:0] segment_offset;
    logic [SizeW-1:0]   segment_size;
  } result_t;

endpackage

>>> rtl/mdsf_cfg_regs.sv
module mdsf_cfg_regs
  import mdsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [VerW-1:0]    tver_q;
  logic [VerLenW-1:0] tlen_q;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3]);

  // Register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tver_q <= '0;
      tlen_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET_VERSION: tver_q <= pwdata;
        REG_TARGET_VER_LEN: tlen_q <= pwdata[VerLenW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_TARGET_VERSION: prdata = tver_q;
      REG_TARGET_VER_LEN: prdata = {{(DataW-VerLenW){1'b0}}, tlen_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.target_version        = tver_q;
  assign cfg_o.target_version_length = tlen_q;

endmodule

>>> rtl/mdsf_scan.sv
module mdsf_scan
  import mdsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output result_t    result_o
);

  logic [MarkerLen-1:0][7:0] win_q, win_d;
  logic [PosW-1:0]           pos_q, pos_d;
  logic [PosW-1:0]           seg_q, seg_d;
  logic [VerLenW-1:0]        vchk_q, vchk_d;
  logic                      leader_q, leader_d;
  logic                      mism_q, mism_d;
  logic                      fin_q, fin_d;

  logic [VerLenW-1:0]        cmp_len;
  logic [7:0]                want;
  logic [PosW-1:0]           pos_inc;

  // Compared prefix length, capped at eight characters
  assign cmp_len = (cfg_i.target_version_length > MaxVerBytes) ? MaxVerBytes
                                                                : cfg_i.target_version_length;
  assign want    = cfg_i.target_version[{vchk_q[2:0], 3'b000} +: 8];
  assign pos_inc = pos_q + 1'b1;

  // Per-byte scan step
  always_comb begin
    win_d    = win_q;
    pos_d    = pos_q;
    seg_d    = seg_q;
    vchk_d   = vchk_q;
    leader_d = leader_q;
    mism_d   = mism_q;
    fin_d    = fin_q;
    result_o = '0;

    if (accept_i) begin
      // bytes past the image limit are not examined
      if (!fin_q && !pos_q[PosW-1]) begin
        if (leader_q && (vchk_q < cmp_len)) begin
          if (data_byte_i != want) begin
            mism_d = 1'b1;
          end
          vchk_d = vchk_q + 1'b1;
        end
        win_d = {data_byte_i, win_q[MarkerLen-1:1]};
        pos_d = pos_inc;

        if (win_d == Marker) begin
          if (!leader_q) begin
            leader_d = 1'b1;
            vchk_d   = '0;
            mism_d   = 1'b0;
          end else if (!mism_d) begin
            result_o.valid          = 1'b1;
            result_o.found          = 1'b1;
            result_o.segment_offset = seg_q[OffsetW-1:0];
            result_o.segment_size   = SizeW'(pos_inc - seg_q);
            fin_d                   = 1'b1;
          end else begin
            // rejected pair: next segment starts after the trailer
            seg_d    = pos_inc;
            leader_d = 1'b0;
            vchk_d   = '0;
            mism_d   = 1'b0;
          end
        end
      end

      // end of stream: report not found if needed, then clear
      if (last_byte_i) begin
        if (!fin_d) begin
          result_o.valid = 1'b1;
        end
        win_d    = '0;
        pos_d    = '0;
        seg_d    = '0;
        vchk_d   = '0;
        leader_d = 1'b0;
        mism_d   = 1'b0;
        fin_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      pos_q    <= '0;
      seg_q    <= '0;
      vchk_q   <= '0;
      leader_q <= 1'b0;
      mism_q   <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      win_q    <= win_d;
      pos_q    <= pos_d;
      seg_q    <= seg_d;
      vchk_q   <= vchk_d;
      leader_q <= leader_d;
      mism_q   <= mism_d;
      fin_q    <= fin_d;
    end
  end

endmodule

>>> rtl/marker_delimited_segment_finder_unit.sv
// A result word appears on the output in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while no result is waiting; the scan state updates once per byte.
// A waiting result holds off new bytes until the receiver takes it; a byte can enter
// in the same cycle that the waiting word drains.
// Reset (rst_ni, async, active low) clears the scan state, the output valid and both
// configuration registers; the scan state also clears after every last byte.
module marker_delimited_segment_finder_unit
  import mdsf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  // byte stream in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  // result out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [OffsetW-1:0]  segment_offset_o,
  output logic [SizeW-1:0]    segment_size_o
);

  cfg_t               cfg;
  result_t            res;
  logic               accept;
  logic               out_valid_q;
  logic               found_q;
  logic [OffsetW-1:0] offset_q;
  logic [SizeW-1:0]   size_q;

  mdsf_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Take a byte whenever the output slot is free or drains this cycle
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  mdsf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .result_o    (res)
  );

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && res.valid) begin
      found_q  <= res.found;
      offset_q <= res.segment_offset;
      size_q   <= res.segment_size;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign segment_offset_o = offset_q;
  assign segment_size_o   = size_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mdsf_pkg::*;

  // cycles without any accepted byte or result word, or APB access, before the run is declared hung
  localparam int WatchLimit = 5000;

  typedef struct packed {
    logic               found;
    logic [OffsetW-1:0] offset;
    logic [SizeW-1:0]   size;
  } seg_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [OffsetW-1:0] segment_offset;
  logic [SizeW-1:0]   segment_size;

  // traffic shaping, percent of cycles spent idle or stalled
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;

  int err_cnt = 0;
  int bytes_sent = 0;
  int results_predicted = 0;
  int stall_cycles = 0;

  // scanner model state and register shadows
  logic [VerW-1:0]              ver_target = '0;
  logic [VerLenW-1:0]           ver_len = '0;
  logic [MarkerLen-1:0][7:0]    scan_window = '0;
  logic [PosW-1:0]              scan_pos = '0;
  logic                         leader_open = 1'b0;
  logic [3:0]                   ver_checked = '0;
  logic                         ver_bad = 1'b0;
  logic [PosW-1:0]              seg_begin = '0;
  logic                         seg_done = 1'b0;

  seg_result_t seg_expect_q[$];
  logic [7:0]  stream_q[$];

  marker_delimited_segment_finder_unit u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .last_byte_i      (last_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .found_o          (found),
    .segment_offset_o (segment_offset),
    .segment_size_o   (segment_size)
  );

  always #2 clk = ~clk;

  // Update the scanner model with one accepted byte, queue any result it causes
  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [3:0] n;
    n = (ver_len > MaxVerBytes) ? MaxVerBytes : ver_len;
    if (!seg_done && !scan_pos[PosW-1]) begin
      if (leader_open && ver_checked < n) begin
        if (b != ver_target[8*ver_checked[2:0] +: 8]) ver_bad = 1'b1;
        ver_checked++;
      end
      scan_window = {b, scan_window[MarkerLen-1:1]};
      scan_pos++;
      if (scan_window == Marker) begin
        if (!leader_open) begin
          leader_open = 1'b1;
          ver_checked = '0;
          ver_bad = 1'b0;
        end else if (!ver_bad) begin
          seg_expect_q.push_back({1'b1, seg_begin[OffsetW-1:0], SizeW'(scan_pos - seg_begin)});
          results_predicted++;
          seg_done = 1'b1;
        end else begin
          // prefix mismatch: next candidate starts right after this trailer
          seg_begin = scan_pos;
          leader_open = 1'b0;
          ver_checked = '0;
          ver_bad = 1'b0;
        end
      end
    end
    if (last) begin
      if (!seg_done) begin
        seg_expect_q.push_back('0);
        results_predicted++;
      end
      scan_window = '0;
      scan_pos = '0;
      leader_open = 1'b0;
      ver_checked = '0;
      ver_bad = 1'b0;
      seg_begin = '0;
      seg_done = 1'b0;
    end
  endfunction

  // Offer one byte, hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (seg_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [DataW-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_TARGET_VERSION) ver_target = val;
    else ver_len = val[VerLenW-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_target(input logic [VerW-1:0] tv, input logic [VerLenW-1:0] len);
    wait_drained();
    apb_write(REG_TARGET_VERSION, tv);
    apb_write(REG_TARGET_VER_LEN, DataW'(len));
  endtask

  function automatic void add_marker(int n);
    for (int i = 0; i < n; i++) stream_q.push_back(Marker[i]);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) stream_q.push_back(8'($urandom));
  endfunction

  // Mostly leader/prefix/trailer streams with random content, some noise and cut-offs
  task automatic build_random_stream();
    int kind, vlen, bad_at, eff, keep;
    stream_q.delete();
    eff = (ver_len > MaxVerBytes) ? int'(MaxVerBytes) : int'(ver_len);
    kind = $urandom_range(9);
    add_noise($urandom_range(3));
    if (kind == 0) begin
      // fragments of markers mixed with junk
      repeat ($urandom_range(1, 4)) begin
        add_marker($urandom_range(1, MarkerLen));
        add_noise($urandom_range(2));
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        add_marker(MarkerLen);
        bad_at = ($urandom_range(2) == 0 && eff > 0) ? $urandom_range(eff - 1) : -1;
        vlen = eff + $urandom_range(2);
        for (int i = 0; i < vlen; i++) begin
          if (i >= eff) stream_q.push_back(8'($urandom));
          else if (i == bad_at) stream_q.push_back(ver_target[8*i +: 8] ^ 8'($urandom_range(1, 255)));
          else stream_q.push_back(ver_target[8*i +: 8]);
        end
        add_noise($urandom_range(2));
        add_marker(MarkerLen);
      end
      add_noise($urandom_range(3));
      // broken stream: cut anywhere
      if (kind == 1) begin
        keep = $urandom_range(1, stream_q.size());
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
    end
    if (stream_q.size() == 0) add_noise(1);
  endtask

  task automatic random_config();
    logic [VerW-1:0] tv;
    logic [VerLenW-1:0] len;
    case ($urandom_range(3))
      0: tv = '0;
      1: tv = '1;
      default: tv = {$urandom, $urandom};
    endcase
    case ($urandom_range(3))
      0: len = '0;
      1: len = MaxVerBytes;
      2: len = '1;
      default: len = VerLenW'($urandom_range(15));
    endcase
    set_target(tv, len);
  endtask

  // Empty prefix, short streams, last byte on the finding byte
  task automatic test_empty_prefix();
    set_target('0, '0);
    stream_q.push_back(8'h00);
    send_stream();
    stream_q.push_back(8'hFF);
    send_stream();
    add_marker(MarkerLen);
    add_marker(MarkerLen);
    send_stream();
    add_marker(MarkerLen);
    add_marker(MarkerLen - 1);
    send_stream();
  endtask

  // Prefix match and mismatch, clamped length, prefix overlapping the trailer
  task automatic test_version_prefix();
    logic [VerW-1:0] tv;
    set_target(64'h3156, 4'd2);
    add_marker(MarkerLen);
    stream_q.push_back(8'h56);
    stream_q.push_back(8'h32);
    add_marker(MarkerLen);
    add_marker(MarkerLen);
    stream_q.push_back(8'h56);
    stream_q.push_back(8'h31);
    stream_q.push_back(8'hFF);
    add_marker(MarkerLen);
    stream_q.push_back(8'h00);
    send_stream();
    set_target('1, '1);
    add_marker(MarkerLen);
    repeat (8) stream_q.push_back(8'hFF);
    add_marker(MarkerLen);
    stream_q.push_back(8'h5A);
    send_stream();
    set_target('0, MaxVerBytes);
    add_marker(MarkerLen);
    repeat (8) stream_q.push_back(8'h00);
    add_marker(MarkerLen);
    send_stream();
    for (int i = 0; i < 8; i++) tv[8*i +: 8] = Marker[i];
    set_target(tv, MaxVerBytes);
    add_marker(MarkerLen);
    add_marker(MarkerLen);
    send_stream();
  endtask

  // Receiver holds off while bytes keep coming, then sender waits for the drain
  task automatic test_backpressure();
    set_target(64'h3156, 4'd2);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = 400;
    repeat (24) begin
      add_noise(1);
      send_stream();
    end
    add_marker(MarkerLen);
    stream_q.push_back(8'h56);
    stream_q.push_back(8'h31);
    add_marker(MarkerLen);
    send_stream();
    wait_drained();
  endtask

  // Random streams under each idling pattern
  task automatic test_random_streams();
    int b0, r0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin src_idle_pct = 0; sink_stall_pct = 0; end
        1: begin src_idle_pct = 71; sink_stall_pct = 0; end
        2: begin src_idle_pct = 0; sink_stall_pct = 71; end
        default: begin src_idle_pct = 13; sink_stall_pct = 13; end
      endcase
      b0 = bytes_sent;
      r0 = results_predicted;
      while (bytes_sent - b0 < 140 || results_predicted - r0 < 3) begin
        if ($urandom_range(4) == 0) random_config();
        build_random_stream();
        send_stream();
      end
    end
  endtask

  // Receiver ready pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : check_results
    seg_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (seg_expect_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result found=%0b offset=%0d size=%0d",
                 $time, found, segment_offset, segment_size);
      end else begin
        want = seg_expect_q.pop_front();
        if (found !== want.found) begin
          err_cnt++;
          $display("%0t: found expected %0b got %0b", $time, want.found, found);
        end
        if (segment_offset !== want.offset) begin
          err_cnt++;
          $display("%0t: segment_offset expected %0d got %0d", $time, want.offset,
                   segment_offset);
        end
        if (segment_size !== want.size) begin
          err_cnt++;
          $display("%0t: segment_size expected %0d got %0d", $time, want.size, segment_size);
        end
      end
    end
  end

  // Hang detection
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_prefix();
    test_version_prefix();
    test_backpressure();
    test_random_streams();
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && seg_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
